// File: hw/rtl/lp2sc_pkg.sv
package lp2sc_pkg;

   // fixed field widths
   localparam int BYTE_BITS        = 8;
   localparam int BUF_LEN_BITS     = 24;
   localparam int PREFIX_SIZE_BITS = 3;
   localparam int ACC_BITS         = 32;

   // buffer position counter width, default
   localparam int LENGTH_BITS_DEFAULT = 24;

   // prefix size register
   localparam logic [PREFIX_SIZE_BITS-1:0] PREFIX_SIZE_SHORT = 3'd3;
   localparam logic [PREFIX_SIZE_BITS-1:0] PREFIX_SIZE_RESET = 3'd4;

   // words held between front and back
   localparam int QUEUE_DEPTH = 2;

endpackage

// File: hw/rtl/lp2sc_if.sv
interface lp2sc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [lp2sc_pkg::BYTE_BITS-1:0]       in_byte;
   logic                                  first_of_buffer;
   logic [lp2sc_pkg::BUF_LEN_BITS-1:0]    buffer_length;

   modport source (output valid, in_byte, first_of_buffer, buffer_length, input ready);
   modport sink   (input valid, in_byte, first_of_buffer, buffer_length, output ready);
endinterface

interface lp2sc_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [lp2sc_pkg::BYTE_BITS-1:0]       out_byte;
   logic                                  written;
   logic                                  malformed;
   logic                                  end_of_buffer;

   modport source (output valid, out_byte, written, malformed, end_of_buffer, input ready);
   modport sink   (input valid, out_byte, written, malformed, end_of_buffer, output ready);
endinterface

interface lp2sc_csr_if;
   logic                                     valid;
   logic                                     ready;
   logic [lp2sc_pkg::PREFIX_SIZE_BITS-1:0]   prefix_size;

   modport source (output valid, prefix_size, input ready);
   modport sink   (input valid, prefix_size, output ready);
endinterface

// File: hw/rtl/length_prefixed_to_start_code.sv
// Converts length-prefixed video units into start-code form, one word (byte) in and one
// word out per cycle, sustained while rsp_ch is ready. Each unit's big-endian length
// prefix of 3 or 4 bytes (csr prefix_size: 3 selects three, any other value four) comes
// out as zeros ending in a one; payload bytes pass unchanged. A unit whose length exceeds
// the bytes from its prefix start to its buffer end is flagged malformed on its last
// prefix byte and the rest of the buffer is left unwritten, as are trailing bytes too
// few for a prefix. first_of_buffer with buffer_length opens a buffer; bytes outside any
// buffer give an all-zero result. A word accepted into the queue is parsed into the
// result register once that register is free or draining, and is handed over from
// there; the rate is set by the single per-word parse update in the back end, which
// carries one byte's prefix, length and payload state each cycle. A two-word queue
// separates the front (buffer position tracking) from the back, and the result register
// takes a new word in the same cycle that the previous result is handed over.
// Write prefix_size only while the block holds no word in flight.
module length_prefixed_to_start_code #(
   parameter int LENGTH_BITS = lp2sc_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   lp2sc_req_if.sink    req_ch,
   lp2sc_rsp_if.source  rsp_ch,
   lp2sc_csr_if.sink    csr_ch
);
   import lp2sc_pkg::*;

   localparam int WORD_BITS = BYTE_BITS + 1 + LENGTH_BITS;

   logic [PREFIX_SIZE_BITS-1:0] prefix_size_ff, prefix_size_in;
   logic                        push_valid;
   logic                        push_ready;
   logic [WORD_BITS-1:0]        push_data;
   logic                        head_valid;
   logic [WORD_BITS-1:0]        head_data;
   logic                        pop;

   // configuration: always ready, hold the last written size
   assign csr_ch.ready = 1'b1;

   always_comb begin
      prefix_size_in = prefix_size_ff;
      if (csr_ch.valid) begin
         prefix_size_in = csr_ch.prefix_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_size_ff <= PREFIX_SIZE_RESET;
      end else begin
         prefix_size_ff <= prefix_size_in;
      end
   end

   // front: resolve each word's position in its buffer
   lp2sc_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decouple front and back
   lp2sc_queue #(
      .DATA_BITS (WORD_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   // back: parse prefixes and payload, drive the result register
   lp2sc_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .prefix_size (prefix_size_ff),
      .head_valid  (head_valid),
      .head_data   (head_data),
      .pop         (pop),
      .rsp_ch      (rsp_ch)
   );

   // an unwritten word carries a zero byte
   a_unwritten_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.written) |-> (rsp_ch.out_byte == '0))
      else $error("unwritten word carries a non-zero byte");

   // a malformed flag only sits on the written start-code byte
   a_malformed_on_code : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.malformed) |->
         (rsp_ch.written && (rsp_ch.out_byte == BYTE_BITS'(1))))
      else $error("malformed flag away from a start-code byte");

   // no result straight out of reset
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result valid straight after reset");
endmodule

// File: hw/rtl/lp2sc_queue.sv
module lp2sc_queue #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = lp2sc_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 head_valid,
   output logic [DATA_BITS-1:0] head_data,
   input  logic                 pop
);
   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0]  slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != COUNT_BITS'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// File: hw/rtl/lp2sc_front.sv
module lp2sc_front #(
   parameter int LENGTH_BITS = lp2sc_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                         clock,
   input  logic                                         reset,
   lp2sc_req_if.sink                                    req_ch,
   output logic                                         push_valid,
   input  logic                                         push_ready,
   output logic [lp2sc_pkg::BYTE_BITS+LENGTH_BITS:0]    push_data
);
   import lp2sc_pkg::*;

   localparam int LEN_IN_BITS = (LENGTH_BITS < BUF_LEN_BITS) ? LENGTH_BITS : BUF_LEN_BITS;

   logic [LENGTH_BITS-1:0] remaining_ff, remaining_in;
   logic [LENGTH_BITS-1:0] left;
   logic                   accept;

   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid;
   assign accept       = req_ch.valid && push_ready;

   // bytes of the buffer still to come, this one included
   assign left = req_ch.first_of_buffer
                 ? LENGTH_BITS'(req_ch.buffer_length[LEN_IN_BITS-1:0])
                 : remaining_ff;

   assign push_data = {req_ch.in_byte, req_ch.first_of_buffer, left};

   always_comb begin
      remaining_in = remaining_ff;
      if (accept) begin
         remaining_in = (left != '0) ? left - 1'b1 : left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
      end else begin
         remaining_ff <= remaining_in;
      end
   end
endmodule

// File: hw/rtl/lp2sc_back.sv
module lp2sc_back #(
   parameter int LENGTH_BITS = lp2sc_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic [lp2sc_pkg::PREFIX_SIZE_BITS-1:0]       prefix_size,
   input  logic                                         head_valid,
   input  logic [lp2sc_pkg::BYTE_BITS+LENGTH_BITS:0]    head_data,
   output logic                                         pop,
   lp2sc_rsp_if.source                                  rsp_ch
);
   import lp2sc_pkg::*;

   localparam logic [1:0] PH_PREFIX  = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_TAIL    = 2'd2;

   localparam int CMP_BITS = ACC_BITS + 1;

   logic [BYTE_BITS-1:0]   hd_byte;
   logic                   hd_first;
   logic [LENGTH_BITS-1:0] hd_left;

   logic [1:0]             phase_ff, phase_in;
   logic [1:0]             idx_ff, idx_in;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic [LENGTH_BITS-1:0] pay_left_ff, pay_left_in;
   logic                   stopped_ff, stopped_in;

   logic [1:0]             ph_cur;
   logic [1:0]             idx_cur;
   logic [ACC_BITS-1:0]    acc_cur;
   logic [ACC_BITS-1:0]    acc_next;
   logic [LENGTH_BITS-1:0] pay_cur;
   logic [LENGTH_BITS-1:0] pay_dec;
   logic                   stp_cur;
   logic [1:0]             last_idx;
   logic                   too_short;
   logic [CMP_BITS-1:0]    from_start;

   logic                   out_valid_ff;
   logic [BYTE_BITS-1:0]   out_byte_ff, out_byte_in;
   logic                   written_ff, written_in;
   logic                   malformed_ff, malformed_in;
   logic                   eob_ff, eob_in;

   assign {hd_byte, hd_first, hd_left} = head_data;

   // take the next word whenever the result register is free or draining
   assign pop = head_valid && (!out_valid_ff || rsp_ch.ready);

   // a new buffer restarts parsing
   assign ph_cur  = hd_first ? PH_PREFIX : phase_ff;
   assign idx_cur = hd_first ? 2'd0 : idx_ff;
   assign acc_cur = hd_first ? '0 : acc_ff;
   assign pay_cur = hd_first ? '0 : pay_left_ff;
   assign stp_cur = hd_first ? 1'b0 : stopped_ff;

   assign last_idx   = (prefix_size == PREFIX_SIZE_SHORT) ? 2'd2 : 2'd3;
   assign too_short  = (prefix_size == PREFIX_SIZE_SHORT) ? (hd_left < LENGTH_BITS'(3))
                                                          : (hd_left < LENGTH_BITS'(4));
   assign acc_next   = {acc_cur[ACC_BITS-BYTE_BITS-1:0], hd_byte};
   assign from_start = CMP_BITS'(hd_left) + CMP_BITS'(idx_cur);
   assign pay_dec    = pay_cur - 1'b1;

   always_comb begin
      phase_in     = ph_cur;
      idx_in       = idx_cur;
      acc_in       = acc_cur;
      pay_left_in  = pay_cur;
      stopped_in   = stp_cur;
      out_byte_in  = '0;
      written_in   = 1'b0;
      malformed_in = 1'b0;
      eob_in       = (hd_left == LENGTH_BITS'(1));
      if ((hd_left != '0) && !stp_cur) begin
         if ((ph_cur == PH_PREFIX) && (idx_cur == 2'd0) && too_short) begin
            phase_in = PH_TAIL;
         end else begin
            unique case (ph_cur)
               PH_PREFIX: begin
                  written_in = 1'b1;
                  if (idx_cur >= last_idx) begin
                     out_byte_in = BYTE_BITS'(1);
                     idx_in      = 2'd0;
                     acc_in      = '0;
                     if ({1'b0, acc_next} > from_start) begin
                        malformed_in = 1'b1;
                        stopped_in   = 1'b1;
                     end else begin
                        pay_left_in = acc_next[LENGTH_BITS-1:0];
                        phase_in    = (acc_next[LENGTH_BITS-1:0] != '0) ? PH_PAYLOAD
                                                                          : PH_PREFIX;
                     end
                  end else begin
                     acc_in = acc_next;
                     idx_in = idx_cur + 1'b1;
                  end
               end
               PH_PAYLOAD: begin
                  out_byte_in = hd_byte;
                  written_in  = 1'b1;
                  pay_left_in = pay_dec;
                  if (pay_dec == '0) begin
                     phase_in = PH_PREFIX;
                     idx_in   = 2'd0;
                  end
               end
               default: begin
                  phase_in = ph_cur;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PREFIX;
         idx_ff       <= '0;
         acc_ff       <= '0;
         pay_left_ff  <= '0;
         stopped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff     <= phase_in;
            idx_ff       <= idx_in;
            acc_ff       <= acc_in;
            pay_left_ff  <= pay_left_in;
            stopped_ff   <= stopped_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_byte_ff  <= out_byte_in;
         written_ff   <= written_in;
         malformed_ff <= malformed_in;
         eob_ff       <= eob_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.out_byte      = out_byte_ff;
   assign rsp_ch.written       = written_ff;
   assign rsp_ch.malformed     = malformed_ff;
   assign rsp_ch.end_of_buffer = eob_ff;
endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the length-prefixed to start-code converter. Each input word is one
// source byte; the checker pairs every output word with the prediction made when the
// input word was accepted.
module tb_top;
   import lp2sc_pkg::*;

   // parse phases of the predictor
   typedef enum logic [1:0] {
      PARSE_PREFIX,
      PARSE_PAYLOAD,
      PARSE_TAIL
   } parse_phase_type;

   // one predicted output word
   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 written;
      logic                 malformed;
      logic                 end_of_buffer;
   } converted_word_type;

   localparam int unsigned SETTLE_CYCLES = 4;     // covers the pipeline latency with margin
   localparam int unsigned WORD_TARGET   = 1550;  // random words that land inside a buffer
   localparam int unsigned MAX_GAP       = 17;

   localparam logic [PREFIX_SIZE_BITS-1:0] PREFIX_SIZE_ZERO = 3'd0;
   localparam logic [PREFIX_SIZE_BITS-1:0] PREFIX_SIZE_TOP  = 3'd7;

   logic clock = 1'b0;
   logic reset;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   lp2sc_req_if req_ch ();
   lp2sc_rsp_if rsp_ch ();
   lp2sc_csr_if csr_ch ();

   length_prefixed_to_start_code dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predictor state, starting from the post-reset values of the block.
   logic [PREFIX_SIZE_BITS-1:0] conv_prefix_size  = PREFIX_SIZE_RESET;
   parse_phase_type             conv_phase        = PARSE_PREFIX;
   logic [1:0]                  conv_prefix_idx   = '0;
   logic [ACC_BITS-1:0]         conv_len_acc      = '0;
   logic [BUF_LEN_BITS-1:0]     conv_bytes_left   = '0;
   logic [BUF_LEN_BITS-1:0]     conv_payload_left = '0;
   logic                        conv_stopped      = 1'b0;

   converted_word_type expected_words[$];   // predictions waiting for their output word

   int unsigned mismatches    = 0;
   int unsigned live_words    = 0;       // accepted words that fell inside a buffer
   int unsigned send_gap_max  = 0;
   int unsigned sink_gap_max  = 0;

   // Advance the predictor by one source byte and return the word it should produce.
   function automatic converted_word_type convert_word(input logic [BYTE_BITS-1:0]    src,
                                                       input logic                    first_flag,
                                                       input logic [BUF_LEN_BITS-1:0] blen);
      converted_word_type      res;
      int unsigned             n;
      logic [BUF_LEN_BITS-1:0] left;
      logic [ACC_BITS:0]       from_start;
      res = '0;
      // the register is sampled on every byte: 3 gives a short prefix, anything else four
      n = (conv_prefix_size == PREFIX_SIZE_SHORT) ? 3 : 4;
      if (first_flag) begin
         conv_phase        = PARSE_PREFIX;
         conv_prefix_idx   = '0;
         conv_len_acc      = '0;
         conv_payload_left = '0;
         conv_stopped      = 1'b0;
         conv_bytes_left   = blen;
      end
      left = conv_bytes_left;
      // outside any buffer the word is all zero and nothing moves
      if (left != 0) begin
         res.end_of_buffer = (left == 1);
         if (!conv_stopped) begin
            // too few bytes left for a whole prefix: the rest is tail, never written
            if (conv_phase == PARSE_PREFIX && conv_prefix_idx == 0 && left < n)
               conv_phase = PARSE_TAIL;
            if (conv_phase == PARSE_PREFIX) begin
               conv_len_acc = {conv_len_acc[ACC_BITS-BYTE_BITS-1:0], src};
               res.written  = 1'b1;
               if (int'(conv_prefix_idx) + 1 >= n) begin
                  // last prefix byte: judge the length against bytes from the prefix start
                  from_start      = left + conv_prefix_idx;
                  res.out_byte    = 8'd1;
                  conv_prefix_idx = '0;
                  if ({1'b0, conv_len_acc} > from_start) begin
                     res.malformed = 1'b1;
                     conv_stopped  = 1'b1;
                  end else begin
                     conv_payload_left = conv_len_acc[BUF_LEN_BITS-1:0];
                     conv_phase = (conv_payload_left != 0) ? PARSE_PAYLOAD : PARSE_PREFIX;
                  end
                  conv_len_acc = '0;
               end else begin
                  conv_prefix_idx = conv_prefix_idx + 2'd1;
               end
            end else if (conv_phase == PARSE_PAYLOAD) begin
               res.out_byte      = src;
               res.written       = 1'b1;
               conv_payload_left = conv_payload_left - 1'b1;
               if (conv_payload_left == 0) begin
                  conv_phase      = PARSE_PREFIX;
                  conv_prefix_idx = '0;
               end
            end
         end
         conv_bytes_left = left - 1'b1;
      end
      return res;
   endfunction

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns  %s mismatch: expected %0h, actual %0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   function automatic int unsigned draw_gap_ceiling();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 2;
         default: return MAX_GAP;
      endcase
   endfunction

   // Offer one word after a random gap and predict its result once it is taken.
   // Valid is left high on return so that back-to-back words need no drop.
   task automatic send_word(input logic [BYTE_BITS-1:0]    src,
                            input logic                    first_flag,
                            input logic [BUF_LEN_BITS-1:0] blen);
      int unsigned gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.in_byte         <= src;
      req_ch.first_of_buffer <= first_flag;
      req_ch.buffer_length   <= blen;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (first_flag ? (blen != 0) : (conv_bytes_left != 0))
         live_words++;
      expected_words.push_back(convert_word(src, first_flag, blen));
   endtask

   // Drop valid and hold until every predicted word has come out, then let the pipe settle.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes only go in while the block is empty.
   task automatic set_prefix_size(input logic [PREFIX_SIZE_BITS-1:0] value);
      wait_for_results();
      csr_ch.valid       <= 1'b1;
      csr_ch.prefix_size <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid     <= 1'b0;
      conv_prefix_size  = value;
   endtask

   // Bytes with no open buffer, and a buffer announced with length zero.
   task automatic test_outside_buffer();
      send_word(8'hFF, 1'b0, 24'hFFFFFF);
      send_word(8'h5A, 1'b1, 24'd0);
      send_word(8'h00, 1'b0, 24'd0);
   endtask

   // Largest buffer length with a unit that just fits, then an all-ones prefix that
   // overruns; the byte after the overrun must stay unwritten.
   task automatic test_length_extremes();
      set_prefix_size(PREFIX_SIZE_TOP);
      send_word(8'h00, 1'b1, 24'hFFFFFF);
      repeat (3) send_word(8'hFF, 1'b0, 24'd0);
      send_word(8'hFF, 1'b0, 24'd0);
      send_word(8'h00, 1'b0, 24'd0);
      // restart mid-payload with a prefix far beyond the buffer
      send_word(8'hFF, 1'b1, 24'hFFFFFF);
      repeat (3) send_word(8'hFF, 1'b0, 24'd0);
      send_word(8'hA5, 1'b0, 24'd0);
   endtask

   // Short prefix: a zero-length unit, then a unit whose payload runs past the buffer end.
   task automatic test_zero_length_unit();
      set_prefix_size(PREFIX_SIZE_SHORT);
      send_word(8'h00, 1'b1, 24'd7);
      send_word(8'h00, 1'b0, 24'd0);
      send_word(8'h00, 1'b0, 24'd0);
      send_word(8'h00, 1'b0, 24'd0);
      send_word(8'h00, 1'b0, 24'd0);
      send_word(8'h03, 1'b0, 24'd0);
      send_word(8'hAB, 1'b0, 24'd0);
   endtask

   // Shrink the prefix size halfway through a prefix; the last byte lands in the tail.
   task automatic test_prefix_resize();
      set_prefix_size(PREFIX_SIZE_ZERO);
      send_word(8'h00, 1'b1, 24'd6);
      send_word(8'h00, 1'b0, 24'd0);
      set_prefix_size(PREFIX_SIZE_SHORT);
      send_word(8'h02, 1'b0, 24'd0);
      send_word(8'hAA, 1'b0, 24'd0);
      send_word(8'h55, 1'b0, 24'd0);
      send_word(8'h77, 1'b0, 24'd0);
   endtask

   // Stray words: random restarts and random lengths over random bytes.
   task automatic send_noise();
      int unsigned             count;
      logic [BUF_LEN_BITS-1:0] blen;
      count = $urandom_range(1, 6);
      repeat (count) begin
         blen = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(0, 8)) : 24'($urandom);
         send_word(8'($urandom), $urandom_range(0, 3) == 0, blen);
      end
   endtask

   // Build one buffer of well-formed units with random payload, now and then with an
   // overlong unit, a unit that runs past the end, or a wrong announced length.
   task automatic send_unit_buffer();
      logic [BYTE_BITS-1:0]    words[$];
      logic [31:0]             unit_len;
      logic [BUF_LEN_BITS-1:0] declared;
      int                      size;
      int                      rem;
      int                      n;
      int                      pick;
      int                      fill;
      n    = (conv_prefix_size == PREFIX_SIZE_SHORT) ? 3 : 4;
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
      rem  = size;
      while (rem >= n) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            unit_len = (n == 4 && pick < 3) ? $urandom : rem + $urandom_range(1, 1000);
            if (unit_len <= rem)
               unit_len = rem + 1;
         end else if (pick < 16) begin
            unit_len = $urandom_range(rem - n + 1, rem);
         end else if (pick < 28 || rem == n) begin
            unit_len = 0;
         end else begin
            unit_len = $urandom_range(1, (rem - n < 24) ? rem - n : 24);
         end
         for (int i = n - 1; i >= 0; i--)
            words.push_back(unit_len[8*i +: 8]);
         rem -= n;
         // an overrun stops parsing: whatever follows is filler
         if (unit_len > rem + n)
            break;
         fill = (unit_len < rem) ? unit_len : rem;
         repeat (fill) words.push_back(8'($urandom));
         rem -= fill;
      end
      repeat (rem) words.push_back(8'($urandom));
      declared = 24'(size);
      if ($urandom_range(0, 9) == 0)
         declared = 24'($urandom_range(0, size + 4));
      foreach (words[i])
         send_word(words[i], i == 0, (i == 0) ? declared : 24'($urandom));
   endtask

   task automatic test_random_traffic();
      int unsigned pick;
      while (live_words < WORD_TARGET) begin
         send_gap_max = draw_gap_ceiling();
         sink_gap_max = draw_gap_ceiling();
         pick = $urandom_range(0, 99);
         if (pick < 6)
            set_prefix_size(($urandom_range(0, 2) == 0) ? PREFIX_SIZE_SHORT
                                                        : 3'($urandom_range(0, 7)));
         else if (pick < 10)
            wait_for_results();
         else if (pick < 20)
            send_noise();
         else
            send_unit_buffer();
      end
   endtask

   // Result side: check each accepted word against the oldest prediction, then draw
   // how long to hold ready low before taking the next one.
   initial begin : result_checker
      converted_word_type got;
      converted_word_type want;
      int unsigned        hold;
      hold = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got = {rsp_ch.out_byte, rsp_ch.written, rsp_ch.malformed, rsp_ch.end_of_buffer};
            if (expected_words.size() == 0) begin
               $display("%0t ns  unexpected word: expected none, actual %0h", $time, got);
               mismatches++;
            end else begin
               want = expected_words.pop_front();
               check_field("out_byte", want.out_byte, got.out_byte);
               check_field("written", 8'(want.written), 8'(got.written));
               check_field("malformed", 8'(want.malformed), 8'(got.malformed));
               check_field("end_of_buffer", 8'(want.end_of_buffer), 8'(got.end_of_buffer));
            end
            hold = $urandom_range(0, sink_gap_max);
            rsp_ch.ready <= (hold == 0);
         end else if (rsp_ch.ready !== 1'b1) begin
            if (hold != 0)
               hold--;
            if (hold == 0)
               rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      reset                  <= 1'b1;
      req_ch.valid           <= 1'b0;
      req_ch.in_byte         <= '0;
      req_ch.first_of_buffer <= 1'b0;
      req_ch.buffer_length   <= '0;
      csr_ch.valid           <= 1'b0;
      csr_ch.prefix_size     <= PREFIX_SIZE_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part with light idling on both sides
      send_gap_max = 3;
      sink_gap_max = 3;
      test_outside_buffer();
      test_length_extremes();
      test_zero_length_unit();
      test_prefix_resize();
      test_random_traffic();

      wait_for_results();
      if (mismatches == 0 && expected_words.size() == 0)
         $display("** length_prefixed_to_start_code: PASSED **");
      else
         $display("** length_prefixed_to_start_code: FAILED **");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #2000000;
      $display("** length_prefixed_to_start_code: FAILED **");
      $finish;
   end

endmodule
